// ===== rtl/core/dpmst_pkg.sv =====
// Package for the dense Prim spanning tree budget checker.
// Holds sizes, codes and the word types shared by the core files.
// Depends on nothing.
`timescale 1ns / 1ps

package dpmst_pkg;

  // Graph and store sizes
  localparam int MaxNodes      = 64;
  localparam int WeightBits    = 16;
  localparam int NodeBits      = $clog2(MaxNodes);
  localparam int CntBits       = $clog2(MaxNodes + 1);
  localparam int StoreDepth    = MaxNodes * MaxNodes;
  localparam int StoreAddrBits = 2 * NodeBits;
  localparam int KeyBits       = WeightBits + 1;
  localparam int TotalBits     = 22;
  localparam logic [TotalBits-1:0] TotalMax = {TotalBits{1'b1}};
  localparam int BudgetBits    = 32;
  localparam int CfgIdxBits    = 1;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgNodeCount = 1'b0,
    CfgBudget    = 1'b1
  } cfg_reg_e;

  // One edge word
  typedef struct packed {
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic [15:0] edge_weight;
    logic        last_edge;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic                 feasible;
    logic [TotalBits-1:0] tree_weight;
  } out_word_t;

  // Access to the weight store
  typedef struct packed {
    logic                     we;
    logic [StoreAddrBits-1:0] waddr;
    logic [WeightBits-1:0]    wdata;
    logic                     re;
    logic [StoreAddrBits-1:0] raddr;
  } wram_req_t;

  // Access to the key store
  typedef struct packed {
    logic                we;
    logic [NodeBits-1:0] waddr;
    logic [KeyBits-1:0]  wdata;
    logic                re;
    logic [NodeBits-1:0] raddr;
  } kram_req_t;

endpackage

// ===== rtl/core/dpmst_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone, no package use.
`timescale 1ns / 1ps

module dpmst_ram #(
  parameter int Depth = 64,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, read data registered while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dpmst_prim.sv =====
// Sequencer of the checker: stores edge words into the weight store and runs
// dense Prim over the weight and key stores. Uses dpmst_pkg.
`timescale 1ns / 1ps

module dpmst_prim import dpmst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  in_word_t              item_i,
  input  logic [CntBits-1:0]    node_count_i,
  input  logic [BudgetBits-1:0] budget_i,
  output logic                  busy,
  output wram_req_t             wram_req_o,
  input  logic [WeightBits-1:0] wram_rdata_i,
  output kram_req_t             kram_req_o,
  input  logic [KeyBits-1:0]    kram_rdata_i,
  output logic                  res_valid_o,
  output out_word_t             result_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMirror = 7'b0000010,
    StInit   = 7'b0000100,
    StPass   = 7'b0001000,
    StDrain  = 7'b0010000,
    StNext   = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  in_word_t              item_q, item_d;
  logic [NodeBits-1:0]   pick_q, pick_d;
  logic [NodeBits-1:0]   v_q, v_d;
  logic [CntBits-1:0]    pass_q, pass_d;
  logic                  first_q, first_d;
  logic [MaxNodes-1:0]   in_tree_q, in_tree_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [NodeBits-1:0]   rd_idx_q, rd_idx_d;
  logic                  min_found_q, min_found_d;
  logic [KeyBits-1:0]    min_key_q, min_key_d;
  logic [NodeBits-1:0]   min_idx_q, min_idx_d;
  logic [TotalBits-1:0]  total_q, total_d;
  logic                  res_valid_q, res_valid_d;
  out_word_t             result_q, result_d;

  logic                  accept;
  logic                  in_range_new, in_range_held;
  logic [KeyBits-1:0]    cand_key, new_key;
  logic                  take;
  logic [TotalBits:0]    sum;
  logic [CntBits-1:0]    last_idx;
  logic [BudgetBits:0]   need;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // Endpoints beyond the store are dropped
  assign in_range_new  = ({1'b0, item_i.from_node} < CntBits'(MaxNodes)) &&
                         ({1'b0, item_i.to_node} < CntBits'(MaxNodes));
  assign in_range_held = ({1'b0, item_q.from_node} < CntBits'(MaxNodes)) &&
                         ({1'b0, item_q.to_node} < CntBits'(MaxNodes));

  // Weight store port: both halves of the symmetric pair, then the Prim reads
  always_comb begin
    wram_req_o       = '0;
    wram_req_o.raddr = {pick_q, v_q};
    wram_req_o.re    = (state_q == StPass);
    if (accept) begin
      wram_req_o.we    = in_range_new;
      wram_req_o.waddr = {item_i.from_node[NodeBits-1:0], item_i.to_node[NodeBits-1:0]};
      wram_req_o.wdata = item_i.edge_weight[WeightBits-1:0];
    end else begin
      wram_req_o.we    = (state_q == StMirror) && in_range_held;
      wram_req_o.waddr = {item_q.to_node[NodeBits-1:0], item_q.from_node[NodeBits-1:0]};
      wram_req_o.wdata = item_q.edge_weight[WeightBits-1:0];
    end
  end

  // Data stage: relax the key of one node and track the minimum
  assign cand_key = {1'b0, wram_rdata_i};
  assign new_key  = (first_q || (cand_key < kram_rdata_i)) ? cand_key : kram_rdata_i;
  assign take     = rd_vld_q && !in_tree_q[rd_idx_q];

  // Key store: read as the row is issued, written back in the cycle after
  assign kram_req_o = '{we:    take,
                        waddr: rd_idx_q,
                        wdata: new_key,
                        re:    (state_q == StPass),
                        raddr: v_q};

  assign sum      = {1'b0, total_q} + (TotalBits + 1)'(min_key_q);
  assign last_idx = node_count_i - CntBits'(1);
  assign need     = (BudgetBits + 1)'(total_q) + (BudgetBits + 1)'(node_count_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    pick_d      = pick_q;
    v_d         = v_q;
    pass_d      = pass_q;
    first_d     = first_q;
    in_tree_d   = in_tree_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    min_found_d = min_found_q;
    min_key_d   = min_key_q;
    min_idx_d   = min_idx_q;
    total_d     = total_q;
    res_valid_d = 1'b0;
    result_d    = result_q;

    if (take && (!min_found_q || (new_key < min_key_q))) begin
      min_found_d = 1'b1;
      min_key_d   = new_key;
      min_idx_d   = rd_idx_q;
    end

    unique case (state_q)
      StIdle: begin
        if (start) begin
          item_d  = item_i;
          state_d = StMirror;
        end
      end
      StMirror: begin
        state_d = item_q.last_edge ? StInit : StIdle;
      end
      StInit: begin
        in_tree_d    = '0;
        in_tree_d[0] = 1'b1;
        pick_d       = '0;
        v_d          = '0;
        pass_d       = '0;
        first_d      = 1'b1;
        total_d      = '0;
        min_found_d  = 1'b0;
        state_d      = (node_count_i == CntBits'(1)) ? StDone : StPass;
      end
      StPass: begin
        rd_vld_d = 1'b1;
        rd_idx_d = v_q;
        if ({1'b0, v_q} == last_idx) begin
          state_d = StDrain;
        end else begin
          v_d = v_q + NodeBits'(1);
        end
      end
      StDrain: begin
        state_d = StNext;
      end
      StNext: begin
        total_d              = sum[TotalBits] ? TotalMax : sum[TotalBits-1:0];
        in_tree_d[min_idx_q] = 1'b1;
        pick_d               = min_idx_q;
        pass_d               = pass_q + CntBits'(1);
        first_d              = 1'b0;
        v_d                  = '0;
        min_found_d          = 1'b0;
        state_d              = ((pass_q + CntBits'(1)) == last_idx) ? StDone : StPass;
      end
      StDone: begin
        result_d.tree_weight = total_q;
        result_d.feasible    = ({1'b0, budget_i} >= need);
        res_valid_d          = 1'b1;
        state_d              = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_tree_q   <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      in_tree_q   <= in_tree_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
      total_q     <= total_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pick_q      <= pick_d;
    v_q         <= v_d;
    pass_q      <= pass_d;
    first_q     <= first_d;
    rd_idx_q    <= rd_idx_d;
    min_found_q <= min_found_d;
    min_key_q   <= min_key_d;
    min_idx_q   <= min_idx_d;
    result_q    <= result_d;
  end

  assign res_valid_o = res_valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/core/dense_prim_mst_budget_check.sv =====
// Usage notes
// Edge words enter on item_i, taken at a clock edge where start is high and
// busy is low. Each word writes its weight into both symmetric entries of a
// 4096 x 16 weight store, one entry per cycle, so a plain edge holds busy
// through the mirror write before the next edge is taken. Every node pair must be
// written before the edge marked last_edge.
// The last edge starts dense Prim from node 0. Each of the n-1 passes reads one
// row of the weight store and the key store, one node per cycle through the
// single read port of each memory, then drains and picks the next node; the
// result strobe res_valid_o rises once the last pass is done and lasts one cycle only,
// with result_o. busy is low again in that cycle.
// The receiver has no back-pressure; result_o is valid only with the strobe.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0: node_count,
// 1: budget) and cfg_data_i; write only while idle.
// Reset (rst_ni low, asynchronous) returns to idle with node_count 2 and
// budget 0; the weight store keeps undefined contents until written.
`timescale 1ns / 1ps

module dense_prim_mst_budget_check import dpmst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              item_i,
  output logic                  res_valid_o,
  output out_word_t             result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [BudgetBits-1:0] cfg_data_i
);

  logic [CntBits-1:0]    node_count_q, node_count_d;
  logic [BudgetBits-1:0] budget_q, budget_d;
  logic [CntBits-1:0]    n_eff;
  wram_req_t             wram_req;
  kram_req_t             kram_req;
  logic [WeightBits-1:0] wram_rdata;
  logic [KeyBits-1:0]    kram_rdata;

  // Configuration registers
  assign cfg_ready_o = !busy;

  always_comb begin
    node_count_d = node_count_q;
    budget_d     = budget_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgNodeCount: node_count_d = cfg_data_i[CntBits-1:0];
        CfgBudget:    budget_d     = cfg_data_i;
        default:      node_count_d = node_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CntBits'(2);
      budget_q     <= '0;
    end else begin
      node_count_q <= node_count_d;
      budget_q     <= budget_d;
    end
  end

  // Clamp the node count to the usable range
  always_comb begin
    priority if (node_count_q < CntBits'(2)) begin
      n_eff = CntBits'(1);
    end else if (node_count_q > CntBits'(MaxNodes)) begin
      n_eff = CntBits'(MaxNodes);
    end else begin
      n_eff = node_count_q;
    end
  end

  // Symmetric weight store
  dpmst_ram #(
    .Depth(StoreDepth),
    .Width(WeightBits)
  ) u_wstore (
    .clk_i  (clk_i),
    .we_i   (wram_req.we),
    .waddr_i(wram_req.waddr),
    .wdata_i(wram_req.wdata),
    .re_i   (wram_req.re),
    .raddr_i(wram_req.raddr),
    .rdata_o(wram_rdata)
  );

  // Per-node key store
  dpmst_ram #(
    .Depth(MaxNodes),
    .Width(KeyBits)
  ) u_kstore (
    .clk_i  (clk_i),
    .we_i   (kram_req.we),
    .waddr_i(kram_req.waddr),
    .wdata_i(kram_req.wdata),
    .re_i   (kram_req.re),
    .raddr_i(kram_req.raddr),
    .rdata_o(kram_rdata)
  );

  // Load and Prim sequencer
  dpmst_prim u_prim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .node_count_i(n_eff),
    .budget_i    (budget_q),
    .busy        (busy),
    .wram_req_o  (wram_req),
    .wram_rdata_i(wram_rdata),
    .kram_req_o  (kram_req),
    .kram_rdata_i(kram_rdata),
    .res_valid_o (res_valid_o),
    .result_o    (result_o)
  );

`ifndef ASSERT_OFF
  // An accepted word always holds busy for its mirror write
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  // The strobe lasts one cycle per computation
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  // A result only appears once the sequencer is back at idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a computation");

  // Key writes belong to a computation, never to edge loading
  a_key_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kram_req.we |-> (busy && !wram_req.we))
    else $error("key store written while loading edges");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the dense Prim spanning tree budget checker.
// Holds a scoreboard class with its own tree predictor, plus the drive tasks.
// Depends on dpmst_pkg and dense_prim_mst_budget_check.
`timescale 1ns / 1ps

module testbench;
  import dpmst_pkg::*;

  localparam int CycleLimit  = 60000000;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 12;
  localparam int RandomWords  = 1350;

  typedef enum int {
    BudKeep, BudRandom, BudZero, BudFull, BudSmall, BudExact, BudShort
  } budget_pick_e;

  // Scoreboard: mirrors the weight store and registers, predicts each tree
  class mst_ledger;
    logic [WeightBits-1:0] store [MaxNodes][MaxNodes];
    logic [6:0]            node_count = 7'd2;
    logic [31:0]           budget = '0;
    out_word_t             owed [$];
    int unsigned           errors = 0;
    int unsigned           jobs = 0;
    int unsigned           checked = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int live_nodes();
      if (node_count < 2) return 1;
      if (node_count > MaxNodes) return MaxNodes;
      return int'(node_count);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_config(cfg_reg_e idx, logic [31:0] data);
      if (idx == CfgNodeCount) node_count = data[6:0];
      else budget = data;
    endfunction

    // Dense Prim from node 0; equal keys go to the lowest node index
    function int unsigned span_weight(int nodes);
      logic [KeyBits-1:0] key [MaxNodes];
      bit                 joined [MaxNodes];
      logic [KeyBits-1:0] low;
      int                 pick;
      int unsigned        sum;
      sum = 0;
      low = '0;
      for (int v = 0; v < MaxNodes; v++) begin
        joined[v] = 1'b0;
        key[v] = {1'b1, {WeightBits{1'b0}}};
      end
      key[0] = '0;
      for (int i = 0; i < nodes; i++) begin
        pick = -1;
        for (int v = 0; v < nodes; v++) begin
          if (!joined[v] && (pick < 0 || key[v] < low)) begin
            pick = v;
            low = key[v];
          end
        end
        if (pick < 0) break;
        joined[pick] = 1'b1;
        sum += low;
        if (sum > TotalMax) sum = TotalMax;
        for (int v = 0; v < nodes; v++) begin
          if (!joined[v] && {1'b0, store[pick][v]} < key[v]) key[v] = {1'b0, store[pick][v]};
        end
      end
      return sum;
    endfunction

    // Accepted edge word: store both entries, predict on the last edge
    function void note_edge(in_word_t w);
      out_word_t   res;
      int unsigned sum;
      int          n;
      store[w.from_node][w.to_node] = w.edge_weight;
      store[w.to_node][w.from_node] = w.edge_weight;
      if (w.last_edge) begin
        n = live_nodes();
        sum = span_weight(n);
        res.tree_weight = sum[TotalBits-1:0];
        res.feasible = ({1'b0, budget} >= 33'(sum) + 33'(n));
        owed.push_back(res);
        jobs++;
      end
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      if (owed.size() == 0) begin
        report($sformatf("result word with no job pending: %h", got));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.tree_weight !== want.tree_weight)
        report($sformatf("job %0d tree_weight %0d, predicted %0d",
                         checked, got.tree_weight, want.tree_weight));
      if (got.feasible !== want.feasible)
        report($sformatf("job %0d feasible %b, predicted %b",
                         checked, got.feasible, want.feasible));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_word_t              edge_word;
  logic                  res_valid;
  out_word_t             res_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [BudgetBits-1:0] cfg_data;

  mst_ledger   ledger = new();
  bit          filled [MaxNodes][MaxNodes];
  bit          steady;
  int unsigned sent_items;
  int unsigned cycles;

  dense_prim_mst_budget_check i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .item_i      (edge_word),
    .res_valid_o (res_valid),
    .result_o    (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result words are strobed for one cycle only
  always @(posedge clk) begin
    if (rst_n && res_valid) ledger.check_result(res_word);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    return (!steady && $urandom_range(99) < 38) ? int'($urandom_range(6, 1)) : 0;
  endfunction

  function automatic in_word_t edge_of(int a, int b, int wt, bit last);
    in_word_t w;
    w.from_node = 6'(a);
    w.to_node = 6'(b);
    w.edge_weight = 16'(wt);
    w.last_edge = last;
    return w;
  endfunction

  // Offer one edge word; start stays high across back-to-back words
  task automatic drive_edge(in_word_t w);
    int          gap;
    logic [31:0] raw;
    gap = pick_gap();
    raw = $urandom;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      edge_word <= raw[$bits(in_word_t)-1:0];
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    edge_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.note_edge(w);
    filled[w.from_node][w.to_node] = 1'b1;
    filled[w.to_node][w.from_node] = 1'b1;
    sent_items++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= $urandom;
  endtask

  // Stop offering words and let the block fall idle
  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    repeat (SettleCycles) @(negedge clk);
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  // One job: set node_count, make sure every pair in use is written, add extra
  // edges, then send the last edge. Boundary budgets end on a self edge, which
  // the tree never reads, so the total is known before it is sent.
  task automatic run_graph(logic [6:0] cfg_nodes, bit rewrite, int wlo, int whi,
                           int extras, budget_pick_e bpick);
    int eff;
    int a;
    int b;
    int unsigned total;
    quiesce();
    write_reg(CfgNodeCount, 32'(cfg_nodes));
    eff = ledger.live_nodes();
    case (bpick)
      BudRandom: write_reg(CfgBudget, $urandom);
      BudZero:   write_reg(CfgBudget, '0);
      BudFull:   write_reg(CfgBudget, '1);
      BudSmall:  write_reg(CfgBudget, $urandom_range(eff * (whi + 1)));
      default: ;
    endcase
    for (int i = 0; i < eff; i++) begin
      for (int j = i; j < eff; j++) begin
        if (rewrite || !filled[i][j]) begin
          if ($urandom_range(1)) drive_edge(edge_of(j, i, $urandom_range(whi, wlo), 1'b0));
          else drive_edge(edge_of(i, j, $urandom_range(whi, wlo), 1'b0));
        end
      end
    end
    for (int k = 0; k < extras; k++) begin
      if ($urandom_range(3) == 0) begin
        a = $urandom_range(MaxNodes - 1);
        b = $urandom_range(MaxNodes - 1);
      end else begin
        a = $urandom_range(eff - 1);
        b = $urandom_range(eff - 1);
      end
      drive_edge(edge_of(a, b, $urandom_range(whi, wlo), 1'b0));
    end
    if (bpick == BudExact || bpick == BudShort) begin
      quiesce();
      total = ledger.span_weight(eff) + eff - int'(bpick == BudShort);
      write_reg(CfgBudget, total);
      a = $urandom_range(eff - 1);
      b = a;
    end else begin
      a = $urandom_range(eff - 1);
      b = $urandom_range(eff - 1);
    end
    drive_edge(edge_of(a, b, $urandom_range(whi, wlo), 1'b1));
  endtask

  initial begin
    int unsigned  random_base;
    int           sel;
    int           wlo;
    int           whi;
    int           eff;
    int           job_no;
    logic [6:0]   cfg_nodes;
    rst_n = 1'b0;
    start = 1'b0;
    edge_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgNodeCount;
    cfg_data = '0;
    steady = 1'b0;
    sent_items = 0;
    cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: two nodes, zero budget, heaviest edge
    drive_edge(edge_of(0, 0, 16'hFFFF, 1'b0));
    drive_edge(edge_of(1, 1, 16'h0000, 1'b0));
    drive_edge(edge_of(1, 0, 16'hFFFF, 1'b1));
    // Node count below two acts as a single node
    run_graph(7'd1, 1'b0, 7, 7, 0, BudExact);
    run_graph(7'd0, 1'b0, 9, 9, 0, BudShort);
    // Equal keys, lowest index wins
    run_graph(7'd4, 1'b0, 3, 3, 0, BudExact);
    run_graph(7'd3, 1'b1, 0, 0, 0, BudFull);
    run_graph(7'd2, 1'b1, 65535, 65535, 0, BudShort);

    // Full graph once, so every later job may read any entry
    run_graph(7'd64, 1'b0, 0, 65535, 0, BudExact);
    run_graph(7'd127, 1'b0, 0, 65535, 4, BudShort);
    run_graph(7'd65, 1'b0, 0, 65535, 4, BudFull);

    // Random jobs, mostly small graphs
    random_base = sent_items;
    job_no = 0;
    while (sent_items - random_base < RandomWords) begin
      steady = (job_no >= 25 && job_no < 45);
      sel = $urandom_range(99);
      if (sel < 8) cfg_nodes = 7'($urandom_range(1));
      else if (sel < 60) cfg_nodes = 7'($urandom_range(8, 2));
      else if (sel < 85) cfg_nodes = 7'($urandom_range(20, 9));
      else if (sel < 93) cfg_nodes = 7'($urandom_range(63, 21));
      else cfg_nodes = 7'($urandom_range(127, 64));
      case ($urandom_range(3))
        0: begin wlo = 0;     whi = 65535; end
        1: begin wlo = 0;     whi = 3;     end
        2: begin wlo = 65534; whi = 65535; end
        default: begin wlo = 0; whi = 1; end
      endcase
      eff = (cfg_nodes < 2) ? 1 : (cfg_nodes > MaxNodes) ? MaxNodes : int'(cfg_nodes);
      run_graph(cfg_nodes, (eff <= 20) ? bit'($urandom_range(1)) : 1'b0, wlo, whi,
                $urandom_range(12), budget_pick_e'($urandom_range(6)));
      job_no++;
    end
    steady = 1'b0;

    quiesce();
    repeat (TailCycles) @(posedge clk);
    if (ledger.pending() != 0)
      ledger.report($sformatf("%0d predicted results never arrived", ledger.pending()));
    $display("summary: %0d edge words, %0d spanning tree jobs, node_count 0..127",
             sent_items, ledger.jobs);
    $display("summary: %0d results checked, %0d mismatches", ledger.checked, ledger.errors);
    if (ledger.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
